// File: hdl/mmrr_pkg.sv
// Shared types and constants for the min/max range remap block.
// Holds the transaction payload structs, register indexes and the sequencer states.
// No dependencies.
package mmrr_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'b1;

    localparam logic REQ_GATHER = 1'b0;
    localparam logic REQ_REMAP  = 1'b1;

    localparam logic signed [DATA_W-1:0] TARGET_LOW_RST  = 32'sd0;
    localparam logic signed [DATA_W-1:0] TARGET_HIGH_RST = 32'sd65536;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] mapped_value;
        logic                     collapsed;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

endpackage

// File: hdl/min_max_range_remap.sv
// Min/max range remap: a gather transaction folds its value into the running minimum and
// maximum. A remap transaction maps its value linearly from the gathered range onto
// [target_low, target_high] and passes through the radix-2 divider, which produces one
// fraction bit per cycle, then a multiply, an add/saturate and an output load step.
// A value at or outside the gathered range skips the divider and goes straight to the
// multiply; a collapsed result goes straight to the output load. The block accepts one
// transaction at a time and holds o_in_stall high until the remap result has been loaded
// into the output register, so the next transaction is taken the cycle after. A finished
// result waits in the output register, so the next transaction can be taken while the
// consumer stalls. The first gather after a remap starts a new set.
module min_max_range_remap
    import mmrr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_payload,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_payload,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int T_W    = FRAC_BITS + 1;
    localparam int PROD_W = FRAC_BITS + 35;

    t_state r_state;
    t_state n_state;

    logic signed [DATA_W-1:0] r_target_low;
    logic signed [DATA_W-1:0] r_target_high;
    logic signed [DATA_W-1:0] r_seen_low;
    logic signed [DATA_W-1:0] r_seen_high;
    logic                     r_have_samples;
    logic                     r_start_new_set;

    logic signed [32:0]       r_diff;
    logic [T_W-1:0]           r_t;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_coll;

    logic      r_out_valid;
    t_out_item r_out;

    logic accept;
    logic is_remap;
    logic out_load;
    logic div_start;
    logic div_done;
    logic [FRAC_BITS-1:0] div_quo;

    logic signed [32:0] w_d;
    logic [32:0]        w_span;
    logic               w_collapse;
    logic               w_d_nonpos;
    logic               w_d_ge_span;
    logic signed [PROD_W-1:0] w_t_ext;
    logic signed [PROD_W-1:0] w_diff_ext;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [33:0] w_q;
    logic signed [34:0] w_sum;
    logic signed [DATA_W-1:0] w_sat;

    assign accept   = i_in_valid && !o_in_stall;
    assign is_remap = (i_in_payload.req_type == REQ_REMAP);

    assign w_d    = {i_in_payload.sample_value[31], i_in_payload.sample_value}
                  - {r_seen_low[31], r_seen_low};
    assign w_span = 33'({r_seen_high[31], r_seen_high} - {r_seen_low[31], r_seen_low});
    assign w_collapse  = !r_have_samples || (r_seen_high == r_seen_low);
    assign w_d_nonpos  = w_d[32] || (w_d == 33'sd0);
    assign w_d_ge_span = !w_d[32] && (33'(w_d) >= w_span);

    // Both multiplier operands are extended to the full product width.
    assign w_t_ext    = $signed({{(PROD_W-T_W){1'b0}}, r_t});
    assign w_diff_ext = $signed({{(PROD_W-33){r_diff[32]}}, r_diff});

    // Arithmetic shift of the product is the floor division by 2^FRAC_BITS.
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_q     = w_shift[33:0];
    assign w_sum   = {{3{r_target_low[31]}}, r_target_low} + {w_q[33], w_q};

    always_comb begin
        if (w_sum[34:31] == 4'b0000 || w_sum[34:31] == 4'b1111) begin
            w_sat = w_sum[31:0];
        end else if (w_sum[34]) begin
            w_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    mmrr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (33'(w_d)),
        .i_divisor  (w_span),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_remap) begin
                    if (w_collapse) begin
                        n_state = S_DONE;
                    end else if (w_d_nonpos || w_d_ge_span) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                div_start  = accept && is_remap && !w_collapse && !w_d_nonpos && !w_d_ge_span;
            end
            S_DONE:  out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_low  <= TARGET_LOW_RST;
            r_target_high <= TARGET_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TARGET_LOW:  r_target_low  <= i_cfg_data;
                CFG_TARGET_HIGH: r_target_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Range statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_low      <= '0;
            r_seen_high     <= '0;
            r_have_samples  <= 1'b0;
            r_start_new_set <= 1'b1;
        end else if (accept) begin
            if (is_remap) begin
                r_start_new_set <= 1'b1;
            end else if (r_start_new_set) begin
                r_seen_low      <= i_in_payload.sample_value;
                r_seen_high     <= i_in_payload.sample_value;
                r_have_samples  <= 1'b1;
                r_start_new_set <= 1'b0;
            end else begin
                if (i_in_payload.sample_value < r_seen_low) begin
                    r_seen_low <= i_in_payload.sample_value;
                end
                if (i_in_payload.sample_value > r_seen_high) begin
                    r_seen_high <= i_in_payload.sample_value;
                end
            end
        end
    end

    // Remap datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && is_remap) begin
            r_diff <= {r_target_high[31], r_target_high} - {r_target_low[31], r_target_low};
            r_coll <= w_collapse;
            r_res  <= r_target_low;
            if (w_d_nonpos) begin
                r_t <= '0;
            end else begin
                r_t <= {1'b1, {FRAC_BITS{1'b0}}};
            end
        end else if (r_state == S_DIV && div_done) begin
            r_t <= {1'b0, div_quo};
        end else if (r_state == S_MUL) begin
            r_prod <= w_t_ext * w_diff_ext;
        end else if (r_state == S_ADD) begin
            r_res <= w_sat;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.mapped_value <= r_res;
            r_out.collapsed    <= r_coll;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_payload = r_out;

endmodule

// File: hdl/mmrr_div.sv
// Radix-2 restoring divider producing a FRAC_BITS-bit fraction of dividend / divisor.
// Expects dividend < divisor; one quotient bit per cycle. Uses no package items.
module mmrr_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [32:0]          i_dividend,
    input  logic [32:0]          i_divisor,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [32:0]          r_rem;
    logic [32:0]          r_div;
    logic [FRAC_BITS-1:0] r_quo;

    logic [33:0] w_shifted;
    logic [34:0] w_trial;
    logic        w_fits;

    assign w_shifted = {r_rem, 1'b0};
    assign w_trial   = {1'b0, w_shifted} - {2'b00, r_div};
    assign w_fits    = !w_trial[34];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so 33 bits always hold it.
            r_rem <= w_fits ? w_trial[32:0] : w_shifted[32:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/mmrr_check.sv
// Port-level checker for the min/max range remap block, bound to the top level.
// Depends on mmrr_pkg for the payload types and register indexes.
module mmrr_check
    import mmrr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in_payload,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_payload,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [DATA_W-1:0]    i_cfg_data
);

    logic [DATA_W-1:0] r_target_low;

    // Shadow of the lower target, to check collapsed results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_low <= TARGET_LOW_RST;
        end else if (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_TARGET_LOW) begin
            r_target_low <= i_cfg_data;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_payload))
        else $error("stalled result changed");

    a_collapsed_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_payload.collapsed |-> o_out_payload.mapped_value == r_target_low)
        else $error("collapsed result differs from lower target");

    a_gather_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_payload.req_type == REQ_GATHER && !o_out_valid
        |=> !o_out_valid)
        else $error("gather transaction produced a result");

    a_remap_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_payload.req_type == REQ_REMAP |=> o_in_stall)
        else $error("remap transaction did not occupy the block");

endmodule

bind min_max_range_remap mmrr_check u_mmrr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_payload  (i_in_payload),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_payload (o_out_payload),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_max_range_remap: directed vectors, then random gather/remap
// sets under several target ranges, checked against an in-bench range predictor.
// Depends on mmrr_pkg and the min_max_range_remap RTL.
module testbench;
    import mmrr_pkg::*;

    localparam int FRAC         = 16;
    localparam int DRAIN_CYCLES = FRAC + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHUNK_ITEMS  = 20;
    localparam int NUM_DIRECTED = 25;

    localparam int IDLE_TX [3] = '{7, 49, 0};
    localparam int IDLE_RX [3] = '{49, 7, 0};

    // Fixed target ranges: reset values, full scale, full scale reversed, degenerate,
    // and a small reversed range below zero. A random range follows in each pass.
    localparam logic [DATA_W-1:0] RANGE_LOW [5] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0005_0000, 32'hFF9C_0000};
    localparam logic [DATA_W-1:0] RANGE_HIGH [5] = '{
        32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000, 32'hFF38_0000};

    typedef struct packed {
        logic              req;
        logic [DATA_W-1:0] value;
        logic              fixed;   // expected result is given in the row
        t_out_item         result;
    } t_vector;

    localparam t_vector DIRECTED [NUM_DIRECTED] = '{
        '{REQ_REMAP,  32'h0005_0000, 1'b1, '{32'sd0, 1'b1}},      // remap with no set gathered
        '{REQ_GATHER, 32'h0007_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h0007_0000, 1'b1, '{32'sd0, 1'b1}},      // zero span
        '{REQ_GATHER, 32'h8000_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h7FFF_FFFF, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h8000_0000, 1'b1, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h7FFF_FFFF, 1'b1, '{32'sd65536, 1'b0}},
        '{REQ_REMAP,  32'h0000_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h4000_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h0000_0000, 1'b0, '{32'sd0, 1'b0}},      // starts a new set
        '{REQ_GATHER, 32'h0064_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'hFFFF_FFFB, 1'b1, '{32'sd0, 1'b0}},      // below the minimum
        '{REQ_REMAP,  32'h00C8_0000, 1'b1, '{32'sd65536, 1'b0}},  // above the maximum
        '{REQ_REMAP,  32'h0032_0000, 1'b1, '{32'sd32768, 1'b0}},
        '{REQ_REMAP,  32'h0064_0000, 1'b1, '{32'sd65536, 1'b0}},
        '{REQ_REMAP,  32'h0000_0000, 1'b1, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h0003_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'hFFFF_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h000A_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h0001_0000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h0000_0001, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h0004_8000, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h7FFF_FFFF, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_GATHER, 32'h7FFF_FFFF, 1'b0, '{32'sd0, 1'b0}},
        '{REQ_REMAP,  32'h7FFF_FFFF, 1'b1, '{32'sd0, 1'b1}}       // single-valued set
    };

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_payload = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    t_out_item            o_out_payload;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_TARGET_LOW;
    logic [DATA_W-1:0]    i_cfg_data   = '0;

    // Predictor state: gathered range and target range.
    logic signed [DATA_W-1:0] rng_low     = '0;
    logic signed [DATA_W-1:0] rng_high    = '0;
    logic                     rng_valid   = 1'b0;
    logic                     rng_restart = 1'b1;
    logic signed [DATA_W-1:0] tgt_low     = TARGET_LOW_RST;
    logic signed [DATA_W-1:0] tgt_high    = TARGET_HIGH_RST;

    t_out_item expected_remaps [$];
    t_out_item want;

    int tx_idle_pct  = IDLE_TX[0];
    int rx_idle_pct  = IDLE_RX[0];
    int cycle_count  = 0;
    int error_count  = 0;
    int items_sent   = 0;
    int n_gather     = 0;
    int n_remap      = 0;
    int n_collapsed  = 0;
    int n_cfg_writes = 0;

    min_max_range_remap #(
        .FRAC_BITS(FRAC)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_payload (i_in_payload),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_payload(o_out_payload),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_remaps.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_remaps.size() == 0) begin
                report_mismatch($sformatf("unexpected result mapped_value=%0d collapsed=%0b",
                                          o_out_payload.mapped_value, o_out_payload.collapsed));
            end else begin
                want = expected_remaps.pop_front();
                if (o_out_payload.mapped_value !== want.mapped_value ||
                    o_out_payload.collapsed !== want.collapsed) begin
                    report_mismatch($sformatf("mapped_value %0d (want %0d), collapsed %0b (want %0b)",
                                              o_out_payload.mapped_value, want.mapped_value,
                                              o_out_payload.collapsed, want.collapsed));
                end
                if (want.collapsed) n_collapsed++;
            end
        end
    end

    // Linear map of v from the gathered range onto the target range.
    function automatic t_out_item remap_sample(input logic signed [DATA_W-1:0] v);
        t_out_item res;
        longint    unit;
        longint    span;
        longint    offset;
        longint    frac;
        longint    sum;
        unit = longint'(1) << FRAC;
        if (!rng_valid || rng_high == rng_low) begin
            res.mapped_value = tgt_low;
            res.collapsed    = 1'b1;
            return res;
        end
        span   = longint'(rng_high) - longint'(rng_low);
        offset = longint'(v) - longint'(rng_low);
        frac   = (offset <= 0) ? 0 : (offset << FRAC) / span;
        if (frac > unit) frac = unit;
        // Arithmetic shift floors the scaled product toward minus infinity.
        sum = longint'(tgt_low) + ((frac * (longint'(tgt_high) - longint'(tgt_low))) >>> FRAC);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        res.mapped_value = sum[DATA_W-1:0];
        res.collapsed    = 1'b0;
        return res;
    endfunction

    task automatic fold_sample(input logic signed [DATA_W-1:0] v);
        if (rng_restart) begin
            rng_low     = v;
            rng_high    = v;
            rng_valid   = 1'b1;
            rng_restart = 1'b0;
        end else begin
            if (v < rng_low) rng_low = v;
            if (v > rng_high) rng_high = v;
        end
    endtask

    // Presents one transaction, holds it until accepted and updates the predictor.
    // Valid is left high on return; a following call drives it again.
    task automatic push_item(input t_in_item item, input logic use_fixed, input t_out_item fixed_res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_payload <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (item.req_type == REQ_REMAP) begin
            n_remap++;
            expected_remaps.insert(expected_remaps.size(),
                                   use_fixed ? fixed_res : remap_sample(item.sample_value));
            rng_restart = 1'b1;
        end else begin
            n_gather++;
            fold_sample(item.sample_value);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_remaps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The write valid stays high between the two writes and drops after the second.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TARGET_LOW) tgt_low = data;
        else tgt_high = data;
        n_cfg_writes++;
    endtask

    task automatic set_targets(input logic [DATA_W-1:0] low, input logic [DATA_W-1:0] high);
        write_reg(CFG_TARGET_LOW, low);
        write_reg(CFG_TARGET_HIGH, high);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] base);
        int unsigned sel;
        int unsigned reach;
        sel   = $urandom_range(0, 15);
        reach = 1 << $urandom_range(2, 26);
        case (sel)
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return base;
            default: return base + $urandom_range(0, reach) - (reach >> 1);
        endcase
    endfunction

    // Mostly a run of gathers followed by remaps around a random center. Some sets hold one
    // value only, some end without a remap and run into the next set, a few are pure noise.
    task automatic send_set();
        t_in_item          item;
        logic [DATA_W-1:0] base;
        int                flavor;
        int                n_gathers;
        int                n_remaps;
        base      = $urandom;
        flavor    = $urandom_range(0, 9);
        n_gathers = $urandom_range(1, 8);
        n_remaps  = (flavor == 2) ? 0 : $urandom_range(1, 6);
        if (flavor == 0) begin
            repeat ($urandom_range(1, 6)) begin
                item.req_type     = 1'($urandom_range(0, 1));
                item.sample_value = $urandom;
                push_item(item, 1'b0, '0);
            end
        end else begin
            repeat (n_gathers) begin
                item.req_type     = REQ_GATHER;
                item.sample_value = (flavor == 1) ? base : pick_value(base);
                push_item(item, 1'b0, '0);
            end
            repeat (n_remaps) begin
                item.req_type     = REQ_REMAP;
                item.sample_value = pick_value(base);
                push_item(item, 1'b0, '0);
            end
        end
    endtask

    initial begin
        t_in_item item;
        int       chunk_end;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            item.req_type     = DIRECTED[k].req;
            item.sample_value = DIRECTED[k].value;
            push_item(item, DIRECTED[k].fixed, DIRECTED[k].result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = IDLE_TX[phase];
            rx_idle_pct = IDLE_RX[phase];
            for (int s = 0; s < 6; s++) begin
                drain_results();
                if (s < 5) set_targets(RANGE_LOW[s], RANGE_HIGH[s]);
                else set_targets($urandom, $urandom);
                chunk_end = items_sent + CHUNK_ITEMS;
                while (items_sent < chunk_end) send_set();
            end
        end

        drain_results();
        $display("Sent %0d gathers and %0d remaps (%0d collapsed) over %0d register writes.",
                 n_gather, n_remap, n_collapsed, n_cfg_writes);
        $display("Target ranges covered default, full-scale, reversed and degenerate settings.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
